FILE: rtl/dijkstra_shortest_path_core_assert.svh
// ----------------------------------------------------------------------------
// dijkstra shortest path core assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DIJKSTRA_SHORTEST_PATH_CORE_ASSERT_SVH
`define DIJKSTRA_SHORTEST_PATH_CORE_ASSERT_SVH

// same-cycle implication
`define DSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/dsp_pkg.sv
// ----------------------------------------------------------------------------
// dsp_pkg
// shared types and constants of the shortest path core
// ----------------------------------------------------------------------------
package dsp_pkg;

	localparam int DSP_NUM_VERTICES = 16;
	localparam int OPCODE_W         = 2;
	localparam int VERTEX_W         = 4;
	localparam int WEIGHT_W         = 16;
	localparam int DIST_W           = 32;

	localparam logic [DIST_W-1:0] DIST_INF = 32'hFFFF_FFFF;
	localparam logic [DIST_W-1:0] DIST_SAT = 32'hFFFF_FFFE;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR    = 2'd0,
		OP_ADD_EDGE = 2'd1,
		OP_RUN      = 2'd2
	} dsp_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EDGE_RD,
		ST_EDGE_AB,
		ST_EDGE_BA,
		ST_INIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_PICK,
		ST_RELAX,
		ST_RELAX_END,
		ST_EMIT_RD,
		ST_EMIT_LD
	} dsp_state_t;

	typedef struct packed {
		logic capture;   // latch input word
		logic edge_clr;  // write empty edge entry at idx
		logic edge_rd;   // read edge entry (a,b)
		logic edge_wr_ab;
		logic edge_wr_ba;
		logic fin_clr;   // clear finalized flags
		logic dist_init; // write start distance at idx
		logic scan_rd;   // read for min search
		logic finalize;  // mark picked vertex done
		logic relax_rd;  // read for relaxation
		logic emit_rd;   // read for result
		logic out_load;  // load output register
	} dsp_cmd_t;

	typedef struct packed {
		logic min_inf;
		logic out_busy;
	} dsp_stat_t;

endpackage

FILE: rtl/dsp_ctrl.sv
// ----------------------------------------------------------------------------
// dsp_ctrl
// sequencer for clear sweep, edge update, search rounds and result output
// ----------------------------------------------------------------------------
module dsp_ctrl import dsp_pkg::*; #(
	parameter int NUM_VERTICES = DSP_NUM_VERTICES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [OPCODE_W-1:0]        opcode,
	input  logic [VERTEX_W-1:0]        src_vertex,
	input  logic [VERTEX_W-1:0]        dst_vertex,
	input  dsp_stat_t                  stat,
	output dsp_cmd_t                   cmd,
	output logic [$clog2(NUM_VERTICES*NUM_VERTICES)-1:0] idx
);

	localparam int VW = $clog2(NUM_VERTICES);
	localparam int AW = $clog2(NUM_VERTICES*NUM_VERTICES);

	dsp_state_t state_q, state_d;
	logic [AW-1:0] cnt_q, cnt_d;
	logic [VW-1:0] round_q, round_d;
	logic accept, edge_ok, clr_last, v_last, round_last;

	assign accept     = in_valid && (state_q == ST_IDLE);
	assign edge_ok    = (int'(src_vertex) < NUM_VERTICES) && (int'(dst_vertex) < NUM_VERTICES);
	assign clr_last   = cnt_q == AW'(NUM_VERTICES*NUM_VERTICES - 1);
	assign v_last     = cnt_q == AW'(NUM_VERTICES - 1);
	assign round_last = round_q == VW'(NUM_VERTICES - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			round_q <= round_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					unique case (dsp_op_t'(opcode))
						OP_CLEAR:    state_d = ST_CLEAR;
						OP_ADD_EDGE: state_d = edge_ok ? ST_EDGE_RD : ST_IDLE;
						OP_RUN:      state_d = ST_INIT;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_EDGE_RD:   state_d = ST_EDGE_AB;
			ST_EDGE_AB:   state_d = ST_EDGE_BA;
			ST_EDGE_BA:   state_d = ST_IDLE;
			ST_INIT:      if (v_last) state_d = ST_SCAN;
			ST_SCAN:      if (v_last) state_d = ST_SCAN_END;
			ST_SCAN_END:  state_d = ST_PICK;
			ST_PICK: begin
				if (!stat.min_inf) state_d = ST_RELAX;
				else state_d = round_last ? ST_EMIT_RD : ST_SCAN;
			end
			ST_RELAX:     if (v_last) state_d = ST_RELAX_END;
			ST_RELAX_END: state_d = round_last ? ST_EMIT_RD : ST_SCAN;
			ST_EMIT_RD:   state_d = ST_EMIT_LD;
			ST_EMIT_LD: begin
				if (!stat.out_busy) state_d = v_last ? ST_IDLE : ST_EMIT_RD;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// sweep and round counters
	always_comb begin
		cnt_d   = cnt_q;
		round_d = round_q;
		unique case (state_q)
			ST_CLEAR:                 cnt_d = clr_last ? '0 : cnt_q + 1'b1;
			ST_INIT, ST_SCAN, ST_RELAX: cnt_d = v_last ? '0 : cnt_q + 1'b1;
			ST_EMIT_LD: begin
				if (!stat.out_busy) cnt_d = v_last ? '0 : cnt_q + 1'b1;
			end
			ST_IDLE: begin
				cnt_d   = '0;
				round_d = '0;
			end
			ST_PICK:      if (stat.min_inf) round_d = round_q + 1'b1;
			ST_RELAX_END: round_d = round_q + 1'b1;
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		idx      = cnt_q;
		unique case (state_q)
			ST_CLEAR:   cmd.edge_clr = 1'b1;
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EDGE_RD: cmd.edge_rd    = 1'b1;
			ST_EDGE_AB: cmd.edge_wr_ab = 1'b1;
			ST_EDGE_BA: cmd.edge_wr_ba = 1'b1;
			ST_INIT: begin
				cmd.dist_init = 1'b1;
				cmd.fin_clr   = 1'b1;
			end
			ST_SCAN:    cmd.scan_rd  = 1'b1;
			ST_PICK:    cmd.finalize = 1'b1;
			ST_RELAX:   cmd.relax_rd = 1'b1;
			ST_EMIT_RD: cmd.emit_rd  = 1'b1;
			ST_EMIT_LD: cmd.out_load = !stat.out_busy;
			default: ;
		endcase
	end

endmodule

FILE: rtl/dsp_datapath.sv
// ----------------------------------------------------------------------------
// dsp_datapath
// edge memory, distance memory, min search, relaxation and output register
// ----------------------------------------------------------------------------
module dsp_datapath import dsp_pkg::*; #(
	parameter int NUM_VERTICES = DSP_NUM_VERTICES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dsp_cmd_t              cmd,
	input  logic [$clog2(NUM_VERTICES*NUM_VERTICES)-1:0] idx,
	input  logic [VERTEX_W-1:0]   src_vertex,
	input  logic [VERTEX_W-1:0]   dst_vertex,
	input  logic [WEIGHT_W-1:0]   edge_weight,
	input  logic                  out_ready,
	output dsp_stat_t             stat,
	output logic                  out_valid,
	output logic [VERTEX_W-1:0]   vertex_index,
	output logic [DIST_W-1:0]     distance,
	output logic                  found,
	output logic                  last
);

	localparam int VW = $clog2(NUM_VERTICES);
	localparam int AW = $clog2(NUM_VERTICES*NUM_VERTICES);
	localparam int NS = NUM_VERTICES*NUM_VERTICES;

	// captured input word
	logic [VERTEX_W-1:0] src_q, dst_q;
	logic [WEIGHT_W-1:0] w_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			src_q <= src_vertex;
			dst_q <= dst_vertex;
			w_q   <= edge_weight;
		end
	end

	logic [VW-1:0] a_v, b_v, idx_v;
	logic          src_ok;
	assign a_v    = VW'(src_q);
	assign b_v    = VW'(dst_q);
	assign idx_v  = idx[VW-1:0];
	assign src_ok = int'(src_q) < NUM_VERTICES;

	// edge memory: {present, weight}
	logic [WEIGHT_W:0]   edge_mem [NS];
	logic [WEIGHT_W:0]   edge_rd_q, edge_wdata;
	logic [AW-1:0]       ab_addr, ba_addr, relax_addr, edge_raddr, edge_waddr;
	logic                edge_re, edge_we;
	logic [WEIGHT_W-1:0] merged_w;
	logic [VW-1:0]       pick_q;

	assign ab_addr    = AW'(int'(a_v) * NUM_VERTICES + int'(b_v));
	assign ba_addr    = AW'(int'(b_v) * NUM_VERTICES + int'(a_v));
	assign relax_addr = AW'(int'(pick_q) * NUM_VERTICES + int'(idx_v));
	assign edge_re    = cmd.edge_rd || cmd.relax_rd;
	assign edge_raddr = cmd.edge_rd ? ab_addr : relax_addr;
	assign edge_we    = cmd.edge_clr || cmd.edge_wr_ab || cmd.edge_wr_ba;

	// repeated pair keeps the smaller weight
	assign merged_w = (!edge_rd_q[WEIGHT_W] || (w_q < edge_rd_q[WEIGHT_W-1:0]))
		? w_q : edge_rd_q[WEIGHT_W-1:0];

	always_comb begin
		priority if (cmd.edge_clr) begin
			edge_waddr = idx;
			edge_wdata = '0;
		end else if (cmd.edge_wr_ab) begin
			edge_waddr = ab_addr;
			edge_wdata = {1'b1, merged_w};
		end else begin
			edge_waddr = ba_addr;
			edge_wdata = {1'b1, merged_w};
		end
	end

	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
		if (edge_re) edge_rd_q <= edge_mem[edge_raddr];
	end

	// distance memory
	logic [DIST_W-1:0] dist_mem [NUM_VERTICES];
	logic [DIST_W-1:0] dist_rd_q, dist_wdata, min_q, sum_sat;
	logic [VW-1:0]     dist_waddr, idx_s1;
	logic              dist_re, dist_we, relax_wr;
	logic              scan_s1, relax_s1;
	logic [DIST_W:0]   sum;

	assign dist_re = cmd.scan_rd || cmd.relax_rd || cmd.emit_rd;

	assign sum     = {1'b0, min_q} + (DIST_W+1)'(edge_rd_q[WEIGHT_W-1:0]);
	assign sum_sat = (sum > {1'b0, DIST_SAT}) ? DIST_SAT : sum[DIST_W-1:0];

	logic [NUM_VERTICES-1:0] fin_q;

	assign relax_wr = relax_s1 && edge_rd_q[WEIGHT_W] && !fin_q[idx_s1] && (sum_sat < dist_rd_q);
	assign dist_we  = cmd.dist_init || relax_wr;

	always_comb begin
		if (cmd.dist_init) begin
			dist_waddr = idx_v;
			dist_wdata = (src_ok && (idx_v == a_v)) ? '0 : DIST_INF;
		end else begin
			dist_waddr = idx_s1;
			dist_wdata = sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
		if (dist_re) begin
			dist_rd_q <= dist_mem[idx_v];
			idx_s1    <= idx_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1  <= 1'b0;
			relax_s1 <= 1'b0;
			fin_q    <= '0;
		end else begin
			scan_s1  <= cmd.scan_rd;
			relax_s1 <= cmd.relax_rd;
			if (cmd.fin_clr) fin_q <= '0;
			else if (cmd.finalize) fin_q[pick_q] <= 1'b1;
		end
	end

	// running minimum, ties go to the higher index
	logic [DIST_W-1:0] cur_min;
	assign cur_min = (idx_s1 == '0) ? DIST_INF : min_q;

	always_ff @(posedge clk) begin
		if (scan_s1) begin
			if (!fin_q[idx_s1] && (dist_rd_q <= cur_min)) begin
				min_q  <= dist_rd_q;
				pick_q <= idx_s1;
			end else if (idx_s1 == '0) begin
				min_q  <= DIST_INF;
				pick_q <= '0;
			end
		end
	end

	// output register
	logic                out_valid_q, found_q, last_q;
	logic [VERTEX_W-1:0] vertex_index_q;
	logic [DIST_W-1:0]   distance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			vertex_index_q <= VERTEX_W'(idx_s1);
			distance_q     <= dist_rd_q;
			found_q        <= fin_q[idx_s1];
			last_q         <= idx_s1 == VW'(NUM_VERTICES - 1);
		end
	end

	assign stat.min_inf  = min_q == DIST_INF;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign vertex_index = vertex_index_q;
	assign distance     = distance_q;
	assign found        = found_q;
	assign last         = last_q;

endmodule

FILE: rtl/dijkstra_shortest_path_core.sv
// ----------------------------------------------------------------------------
// dijkstra_shortest_path_core
// undirected weighted graph store with single-source shortest path search
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) takes one command word: clear graph,
// add undirected edge, or run a search from src_vertex
// output channel (out_valid/out_ready) gives one result word per vertex
// after a run, in index order, with last set on the final vertex
// steps per command word:
//   add edge: accept, read, write a->b, write b->a
//   clear: accept, then a sweep writing one edge entry per cycle
//   run: accept, init, rounds, output; each round scans V distances, then
//   relaxes V neighbors unless the picked vertex is unreachable
// ignored words (unused opcode, endpoint out of range) are dropped
// reset: control clears at once, then a pass over all V*V entries empties the edge
//   memory; in_ready stays low until it ends
// receiver stall: the output register holds its word and the result
//   sequencer waits; a new command is taken once the last word is loaded
// ----------------------------------------------------------------------------
module dijkstra_shortest_path_core import dsp_pkg::*; #(
	parameter int NUM_VERTICES = DSP_NUM_VERTICES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [VERTEX_W-1:0] src_vertex,
	input  logic [VERTEX_W-1:0] dst_vertex,
	input  logic [WEIGHT_W-1:0] edge_weight,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VERTEX_W-1:0] vertex_index,
	output logic [DIST_W-1:0]   distance,
	output logic                found,
	output logic                last
);

	localparam int AW = $clog2(NUM_VERTICES*NUM_VERTICES);

	// command and status between sequencer and datapath
	dsp_cmd_t      cmd;
	dsp_stat_t     stat;
	logic [AW-1:0] idx;

	// sequencer: clear sweep, edge update, rounds, result output
	dsp_ctrl #(
		.NUM_VERTICES (NUM_VERTICES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.src_vertex (src_vertex),
		.dst_vertex (dst_vertex),
		.stat       (stat),
		.cmd        (cmd),
		.idx        (idx)
	);

	// memories, min search, relaxation adder, output register
	dsp_datapath #(
		.NUM_VERTICES (NUM_VERTICES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.idx          (idx),
		.src_vertex   (src_vertex),
		.dst_vertex   (dst_vertex),
		.edge_weight  (edge_weight),
		.out_ready    (out_ready),
		.stat         (stat),
		.out_valid    (out_valid),
		.vertex_index (vertex_index),
		.distance     (distance),
		.found        (found),
		.last         (last)
	);

endmodule

FILE: rtl/dsp_checker.sv
// ----------------------------------------------------------------------------
// dsp_checker
// port-level checks of the shortest path core
// ----------------------------------------------------------------------------
`include "dijkstra_shortest_path_core_assert.svh"

module dsp_checker import dsp_pkg::*; #(
	parameter int NUM_VERTICES = DSP_NUM_VERTICES
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [VERTEX_W-1:0] vertex_index,
	input logic [DIST_W-1:0]   distance,
	input logic                found,
	input logic                last
);

	localparam logic [VERTEX_W-1:0] LAST_IDX = VERTEX_W'(NUM_VERTICES - 1);

	// stalled word holds
	`DSP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(vertex_index) && $stable(distance) && $stable(found) && $stable(last), "result word changed while stalled")

	// last marks the top vertex
	`DSP_ASSERT_NOW(a_last_index, clk, arst_n, out_valid && last, vertex_index == LAST_IDX, "last on wrong vertex")

	// no command taken while results remain
	`DSP_ASSERT_NOW(a_busy_emit, clk, arst_n, out_valid && !last, !in_ready, "input taken mid result")

	// back-to-back results step the index by one
	`DSP_ASSERT_NEXT(a_index_step, clk, arst_n, out_valid && out_ready && !last, !out_valid || (vertex_index == $past(vertex_index) + 4'd1), "result index out of order")

endmodule

bind dijkstra_shortest_path_core dsp_checker #(
	.NUM_VERTICES (NUM_VERTICES)
) u_dsp_checker (.*);

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the shortest path core: a clocked driver sends
// clear, add-edge, run and unused command words from a queue, a software
// copy of the graph works out the distance words of every run, and a clocked
// monitor compares each result word, field by field, as it leaves the block
// ----------------------------------------------------------------------------
module tb_top;
	import dsp_pkg::*;

	localparam int NV             = DSP_NUM_VERTICES;
	localparam int RAND_ITEMS     = 460;
	localparam int GAP_MAX        = 8;
	// a trailing clear sweeps V*V edge entries, and the drain must outlast it
	localparam int DRAIN_CYCLES   = 2 * NV * NV;
	// longest quiet stretch: reset sweep, or a run
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int PRINT_MAX      = 200;

	// opcode value the block must ignore
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [VERTEX_W-1:0] src;
		logic [VERTEX_W-1:0] dst;
		logic [WEIGHT_W-1:0] w;
	} cmd_word_t;

	typedef struct packed {
		logic [VERTEX_W-1:0] vtx;
		logic [DIST_W-1:0]   dval;
		logic                fnd;
		logic                lst;
	} vtx_report_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	// block ports, all known from time zero
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic [OPCODE_W-1:0] opcode      = '0;
	logic [VERTEX_W-1:0] src_vertex  = '0;
	logic [VERTEX_W-1:0] dst_vertex  = '0;
	logic [WEIGHT_W-1:0] edge_weight = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [VERTEX_W-1:0] vertex_index;
	logic [DIST_W-1:0]   distance;
	logic                found;
	logic                last;

	dijkstra_shortest_path_core #(
		.NUM_VERTICES(NV)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.src_vertex   (src_vertex),
		.dst_vertex   (dst_vertex),
		.edge_weight  (edge_weight),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vertex_index (vertex_index),
		.distance     (distance),
		.found        (found),
		.last         (last)
	);

	// command words waiting to be sent, and distance words owed by the block
	cmd_word_t   cmd_queue[$];
	vtx_report_t dist_reports[$];

	// software copy of the graph and of the last search
	logic                edge_on [NV][NV];
	logic [WEIGHT_W-1:0] edge_w  [NV][NV];
	logic [DIST_W-1:0]   path_dist [NV];
	logic                path_done [NV];

	int err_count    = 0;
	int quiet_cycles = 0;

	task automatic note_error(input string msg);
		if (err_count < PRINT_MAX)
			$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// a repeated pair keeps the smaller weight
	task automatic put_edge(input int a, input int b, input logic [WEIGHT_W-1:0] w);
		if (!edge_on[a][b] || w < edge_w[a][b])
			edge_w[a][b] = w;
		edge_on[a][b] = 1'b1;
	endtask

	// apply one accepted command word to the graph copy; a run queues the
	// distance word of every vertex in index order
	task automatic graph_step(input cmd_word_t c);
		int                  v;
		int                  rnd;
		int                  pick;
		logic [DIST_W-1:0]   min_d;
		logic [DIST_W-1:0]   du;
		logic [DIST_W:0]     sum;
		vtx_report_t         r;
		case (c.op)
			OP_CLEAR: begin
				foreach (edge_on[a, b])
					edge_on[a][b] = 1'b0;
			end
			OP_ADD_EDGE: begin
				// endpoints past the vertex count are dropped
				if (c.src < NV && c.dst < NV) begin
					put_edge(c.src, c.dst, c.w);
					put_edge(c.dst, c.src, c.w);
				end
			end
			OP_RUN: begin
				for (v = 0; v < NV; v++) begin
					path_dist[v] = DIST_INF;
					path_done[v] = 1'b0;
				end
				// a source past the vertex count leaves everything unreachable
				if (c.src < NV)
					path_dist[c.src] = '0;
				for (rnd = 0; rnd + 1 < NV; rnd++) begin
					// smallest unfinished distance, highest index on ties
					min_d = DIST_INF;
					pick  = 0;
					for (v = 0; v < NV; v++) begin
						if (!path_done[v] && path_dist[v] <= min_d) begin
							min_d = path_dist[v];
							pick  = v;
						end
					end
					path_done[pick] = 1'b1;
					du = path_dist[pick];
					if (du != DIST_INF) begin
						for (v = 0; v < NV; v++) begin
							if (edge_on[pick][v] && !path_done[v]) begin
								sum = {1'b0, du} + edge_w[pick][v];
								if (sum > DIST_SAT)
									sum = DIST_SAT;
								if (sum[DIST_W-1:0] < path_dist[v])
									path_dist[v] = sum[DIST_W-1:0];
							end
						end
					end
				end
				for (v = 0; v < NV; v++) begin
					r.vtx  = v[VERTEX_W-1:0];
					r.dval = path_dist[v];
					r.fnd  = path_done[v];
					r.lst  = (v + 1 == NV);
					dist_reports.push_back(r);
				end
			end
			default: ; // unused opcode does nothing
		endcase
	endtask

	task automatic push_cmd(input logic [OPCODE_W-1:0] op, input int src, input int dst,
			input int w);
		cmd_word_t c;
		c.op  = op;
		c.src = src[VERTEX_W-1:0];
		c.dst = dst[VERTEX_W-1:0];
		c.w   = w[WEIGHT_W-1:0];
		cmd_queue.push_back(c);
	endtask

	function automatic int rand_vertex();
		return $urandom_range(0, (1 << VERTEX_W) - 1);
	endfunction

	// weight styles: tiny values to force distance ties, small values,
	// values near the top of the field, and the full range
	function automatic int pick_weight(input int style);
		case (style)
			0:       return $urandom_range(0, 3);
			1:       return $urandom_range(0, 15);
			2:       return $urandom_range((1 << WEIGHT_W) - 16, (1 << WEIGHT_W) - 1);
			default: return $urandom_range(0, (1 << WEIGHT_W) - 1);
		endcase
	endfunction

	function automatic int draw_gap(input logic calm);
		return calm ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	// ------------------------------------------------------------------------
	// driver: presents one command word at a time, holds it until taken,
	// then idles a drawn number of cycles before the next word
	// ------------------------------------------------------------------------
	cmd_word_t tx_cur;
	int        tx_gap  = 0;
	logic      tx_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			opcode      <= '0;
			src_vertex  <= '0;
			dst_vertex  <= '0;
			edge_weight <= '0;
		end else begin
			if (in_valid && in_ready) begin
				graph_step(tx_cur);
				// switch between idle and back-to-back stretches now and then
				if ($urandom_range(0, 31) == 0)
					tx_calm = !tx_calm;
				tx_gap = draw_gap(tx_calm);
			end
			if (in_valid && !in_ready) begin
				// word not taken yet, hold it
			end else if (tx_gap != 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				tx_cur       = cmd_queue.pop_front();
				in_valid    <= 1'b1;
				opcode      <= tx_cur.op;
				src_vertex  <= tx_cur.src;
				dst_vertex  <= tx_cur.dst;
				edge_weight <= tx_cur.w;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: checks each taken result word against the oldest owed one,
	// stalls the output for a drawn number of cycles per word, and counts
	// cycles in which neither channel moves a word
	// ------------------------------------------------------------------------
	vtx_report_t rx_want;
	int          rx_wait = 0;
	logic        rx_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (dist_reports.size() == 0) begin
					note_error($sformatf("word for vertex %0d with no result owed",
						vertex_index));
				end else begin
					rx_want = dist_reports.pop_front();
					if (vertex_index !== rx_want.vtx)
						note_error($sformatf("vertex_index got %0d want %0d",
							vertex_index, rx_want.vtx));
					if (distance !== rx_want.dval)
						note_error($sformatf("vertex %0d distance got %0d want %0d",
							rx_want.vtx, distance, rx_want.dval));
					if (found !== rx_want.fnd)
						note_error($sformatf("vertex %0d found got %b want %b",
							rx_want.vtx, found, rx_want.fnd));
					if (last !== rx_want.lst)
						note_error($sformatf("vertex %0d last got %b want %b",
							rx_want.vtx, last, rx_want.lst));
				end
				if ($urandom_range(0, 31) == 0)
					rx_calm = !rx_calm;
				rx_wait = draw_gap(rx_calm);
				out_ready <= (rx_wait == 0);
			end else if (rx_wait != 0) begin
				rx_wait--;
				out_ready <= (rx_wait == 0);
			end else begin
				out_ready <= 1'b1;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// watchdog
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("dijkstra_shortest_path_core regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int rand_items;
		int n_edges;
		int style;
		int k;

		foreach (edge_on[a, b]) begin
			edge_on[a][b] = 1'b0;
			edge_w[a][b]  = '0;
		end

		// directed part
		// search on an empty graph: ties resolve to the highest index
		push_cmd(OP_RUN, 0, 0, 0);
		// unused opcode
		push_cmd(OP_UNUSED, 5, 9, 16'hA5A5);
		// repeated pair keeps the smaller weight, either direction
		push_cmd(OP_ADD_EDGE, 0, 15, 16'hFFFF);
		push_cmd(OP_ADD_EDGE, 0, 15, 5);
		push_cmd(OP_ADD_EDGE, 15, 0, 7);
		// self loop, zero weight edge, maximum weights in a chain
		push_cmd(OP_ADD_EDGE, 3, 3, 0);
		push_cmd(OP_ADD_EDGE, 15, 15, 16'hFFFF);
		push_cmd(OP_ADD_EDGE, 15, 14, 0);
		push_cmd(OP_ADD_EDGE, 14, 1, 16'hFFFF);
		push_cmd(OP_ADD_EDGE, 1, 2, 16'hFFFF);
		push_cmd(OP_ADD_EDGE, 2, 4, 1);
		push_cmd(OP_ADD_EDGE, 4, 3, 16'hFFFF);
		push_cmd(OP_ADD_EDGE, 10, 11, 16'h5555);
		push_cmd(OP_RUN, 15, 0, 0);
		push_cmd(OP_RUN, 0, 15, 16'hFFFF);
		// isolated source, then a source with a single neighbor
		push_cmd(OP_RUN, 9, 0, 0);
		push_cmd(OP_RUN, 11, 0, 0);
		// clear, then a re-added pair takes the new weight even if larger
		push_cmd(OP_CLEAR, 15, 15, 16'hFFFF);
		push_cmd(OP_RUN, 15, 0, 0);
		push_cmd(OP_ADD_EDGE, 0, 15, 100);
		push_cmd(OP_UNUSED, 0, 15, 1);
		push_cmd(OP_RUN, 0, 0, 0);

		// random part: graph sessions ending in a search, with noise
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				push_cmd(OP_UNUSED, rand_vertex(), rand_vertex(),
					pick_weight(3));
			end else begin
				if ($urandom_range(0, 2) == 0) begin
					push_cmd(OP_CLEAR, rand_vertex(), rand_vertex(), pick_weight(3));
					rand_items++;
				end
				n_edges = $urandom_range(0, 14);
				if ($urandom_range(0, 7) == 0)
					n_edges = $urandom_range(20, 48);
				style = $urandom_range(0, 3);
				for (k = 0; k < n_edges; k++) begin
					// a stray unused word now and then inside a session
					if ($urandom_range(0, 19) == 0)
						push_cmd(OP_UNUSED, rand_vertex(), rand_vertex(),
							pick_weight(3));
					push_cmd(OP_ADD_EDGE, rand_vertex(), rand_vertex(),
						pick_weight(style));
					rand_items++;
				end
				push_cmd(OP_RUN, rand_vertex(), rand_vertex(), pick_weight(3));
				rand_items++;
				// a second search of the same graph from elsewhere
				if ($urandom_range(0, 3) == 0) begin
					push_cmd(OP_RUN, rand_vertex(), rand_vertex(), pick_weight(3));
					rand_items++;
				end
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// all words sent, all results seen, then let a trailing sweep finish
		while (cmd_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (dist_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("dijkstra_shortest_path_core regression: pass");
		else
			$display("dijkstra_shortest_path_core regression: fail");
		$finish;
	end

endmodule
